// ===== sv/spk_pkg.sv =====
// ---------------------------------------------------------------------------
// Speck cipher core package
// Shared types, command codes and default parameters of the Speck engine.
// ---------------------------------------------------------------------------
`default_nettype none

package spk_pkg;

   localparam int FIELD_BITS    = 64;
   localparam int CMD_BITS      = 2;
   localparam int KEY_DEPTH     = 32;
   localparam int KEY_ADDR_BITS = 5;

   localparam int DEF_WORD_BITS = 64;
   localparam int DEF_ROUNDS    = 32;
   localparam int DEF_ROT_RIGHT = 8;
   localparam int DEF_ROT_LEFT  = 3;

   localparam logic [CMD_BITS-1:0] CMD_LOAD    = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_ENCRYPT = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_DECRYPT = 2'd2;

   typedef struct packed {
      logic [CMD_BITS-1:0]      command;
      logic [KEY_ADDR_BITS-1:0] key_slot;
      logic [FIELD_BITS-1:0]    key_value;
      logic [FIELD_BITS-1:0]    block_high;
      logic [FIELD_BITS-1:0]    block_low;
   } spk_req_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] result_high;
      logic [FIELD_BITS-1:0] result_low;
   } spk_rsp_type;

endpackage

`default_nettype wire

// ===== sv/spk_ram.sv =====
// ---------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module spk_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/spk_round.sv =====
// ---------------------------------------------------------------------------
// Speck round unit
// One forward or inverse Speck round over a two-word state.
// ---------------------------------------------------------------------------
`default_nettype none

module spk_round #(
   parameter int WORD_BITS = 64,
   parameter int ROT_RIGHT = 8,
   parameter int ROT_LEFT  = 3
) (
   input  wire logic                 decrypt,
   input  wire logic [WORD_BITS-1:0] x_cur,
   input  wire logic [WORD_BITS-1:0] y_cur,
   input  wire logic [WORD_BITS-1:0] round_key,
   output logic      [WORD_BITS-1:0] x_next,
   output logic      [WORD_BITS-1:0] y_next
);

   logic [WORD_BITS-1:0] x_ror;
   logic [WORD_BITS-1:0] enc_x;
   logic [WORD_BITS-1:0] enc_y;
   logic [WORD_BITS-1:0] xy_mix;
   logic [WORD_BITS-1:0] dec_y;
   logic [WORD_BITS-1:0] dec_diff;
   logic [WORD_BITS-1:0] dec_x;

   // Forward round
   assign x_ror = (x_cur >> ROT_RIGHT) | (x_cur << (WORD_BITS - ROT_RIGHT));
   assign enc_x = (x_ror + y_cur) ^ round_key;
   assign enc_y = ((y_cur << ROT_LEFT) | (y_cur >> (WORD_BITS - ROT_LEFT))) ^ enc_x;

   // Inverse round: undo the y update first, then the modular addition
   assign xy_mix   = x_cur ^ y_cur;
   assign dec_y    = (xy_mix >> ROT_LEFT) | (xy_mix << (WORD_BITS - ROT_LEFT));
   assign dec_diff = (x_cur ^ round_key) - dec_y;
   assign dec_x    = (dec_diff << ROT_RIGHT) | (dec_diff >> (WORD_BITS - ROT_RIGHT));

   assign x_next = decrypt ? dec_x : enc_x;
   assign y_next = decrypt ? dec_y : enc_y;

endmodule

`default_nettype wire

// ===== sv/speck_block_cipher_core.sv =====
// ---------------------------------------------------------------------------
// Speck block cipher core
// Iterative Speck engine with a store of precomputed round keys.
// ---------------------------------------------------------------------------
// Usage:
//   A request beat carries a command. A load writes key_value into round key
//   entry key_slot and gives no response. An encrypt or decrypt runs ROUNDS
//   rounds over {block_high, block_low} and gives one response beat with the
//   result words, zero above WORD_BITS. Command code 3 is taken and ignored.
//   A cipher beat runs its rounds in the single round unit, one round per
//   cycle, with the round key addressed in the key RAM in the cycle before
//   it is used. The result and rsp_valid are registered at the end of the
//   last round if the output register is free, else once it frees, and a
//   new request is not taken before the block has reached that register.
//   req_ready is high only while the core is idle. The response sits in an
//   output register, so the core goes idle while it waits to be taken; if a
//   second result finishes before the first is taken, the core holds it and
//   stays busy until the output register frees.
//   Reset returns the core to idle and drops rsp_valid. Key entries are
//   undefined after reset until loaded.
// ---------------------------------------------------------------------------
`default_nettype none

module speck_block_cipher_core #(
   parameter int WORD_BITS = spk_pkg::DEF_WORD_BITS,
   parameter int ROUNDS    = spk_pkg::DEF_ROUNDS,
   parameter int ROT_RIGHT = spk_pkg::DEF_ROT_RIGHT,
   parameter int ROT_LEFT  = spk_pkg::DEF_ROT_LEFT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire spk_pkg::spk_req_type req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output spk_pkg::spk_rsp_type      rsp_data
);

   import spk_pkg::*;

   localparam int RND_BITS = (ROUNDS > 1) ? $clog2(ROUNDS) : 1;
   localparam logic [RND_BITS-1:0] LAST_ROUND = RND_BITS'(ROUNDS - 1);
   localparam logic [KEY_ADDR_BITS-1:0] DEC_START =
      KEY_ADDR_BITS'((ROUNDS - 1) % KEY_DEPTH);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_WB
   } state_type;

   state_type                state_ff, state_in;
   logic [RND_BITS-1:0]      round_ff, round_in;
   logic [KEY_ADDR_BITS-1:0] kidx_ff, kidx_in;
   logic                     decrypt_ff, decrypt_in;
   logic [WORD_BITS-1:0]     x_ff, x_in;
   logic [WORD_BITS-1:0]     y_ff, y_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   spk_rsp_type              rsp_data_ff, rsp_data_in;

   logic                     req_fire;
   logic                     is_cipher;
   logic                     out_free;
   logic [KEY_ADDR_BITS-1:0] kidx_step;
   logic [KEY_ADDR_BITS-1:0] rd_addr;
   logic [WORD_BITS-1:0]     round_key;
   logic [WORD_BITS-1:0]     x_rnd;
   logic [WORD_BITS-1:0]     y_rnd;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign is_cipher = (req_data.command == CMD_ENCRYPT) ||
                      (req_data.command == CMD_DECRYPT);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign kidx_step = decrypt_ff ? (kidx_ff - 1'b1) : (kidx_ff + 1'b1);
   assign kidx_in   = (req_fire && (req_data.command == CMD_DECRYPT)) ? DEC_START :
                      req_fire ? '0 : kidx_step;

   // The RAM read is registered, so the key for the coming round is
   // addressed in the cycle before it is used.
   assign rd_addr = kidx_in;

   spk_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (KEY_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (req_fire && (req_data.command == CMD_LOAD)),
      .wr_addr (req_data.key_slot),
      .wr_data (req_data.key_value[WORD_BITS-1:0]),
      .rd_addr (rd_addr),
      .rd_data (round_key)
   );

   spk_round #(
      .WORD_BITS (WORD_BITS),
      .ROT_RIGHT (ROT_RIGHT),
      .ROT_LEFT  (ROT_LEFT)
   ) u_round (
      .decrypt   (decrypt_ff),
      .x_cur     (x_ff),
      .y_cur     (y_ff),
      .round_key (round_key),
      .x_next    (x_rnd),
      .y_next    (y_rnd)
   );

   always_comb begin
      state_in     = state_ff;
      round_in     = round_ff;
      decrypt_in   = decrypt_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire && is_cipher) begin
               state_in   = S_RUN;
               round_in   = '0;
               decrypt_in = (req_data.command == CMD_DECRYPT);
               x_in       = req_data.block_high[WORD_BITS-1:0];
               y_in       = req_data.block_low[WORD_BITS-1:0];
            end
         end
         S_RUN: begin
            x_in     = x_rnd;
            y_in     = y_rnd;
            round_in = round_ff + 1'b1;
            if (round_ff == LAST_ROUND) begin
               if (out_free) begin
                  state_in                = S_IDLE;
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.result_high = FIELD_BITS'(x_rnd);
                  rsp_data_in.result_low  = FIELD_BITS'(y_rnd);
               end else begin
                  state_in = S_WB;
               end
            end
         end
         S_WB: begin
            if (out_free) begin
               state_in                = S_IDLE;
               rsp_valid_in            = 1'b1;
               rsp_data_in.result_high = FIELD_BITS'(x_ff);
               rsp_data_in.result_low  = FIELD_BITS'(y_ff);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         round_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         round_ff     <= round_in;
      end
      kidx_ff     <= kidx_in;
      decrypt_ff  <= decrypt_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A response only appears at the end of a block's rounds.
   a_rsp_from_core: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_RUN) || ($past(state_ff) == S_WB))
      else $error("response raised without a finished block");

   a_cipher_starts: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_cipher |=> (state_ff == S_RUN) && (round_ff == '0))
      else $error("cipher beat did not start the round sequence");

   a_round_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (round_ff <= LAST_ROUND))
      else $error("round counter ran past the last round");

   a_wb_when_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |-> rsp_valid_ff)
      else $error("result held back while the output register was free");

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire && !is_cipher |=> (state_ff == S_IDLE))
      else $error("key load or unused command left the core busy");

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Speck block cipher core testbench
// Loads a full round key schedule, then drives directed and random encrypt,
// decrypt, key load and unused command beats with random gaps on both sides,
// and checks every response against a cycle-free Speck predictor.
// ---------------------------------------------------------------------------

module tb_top;

   import spk_pkg::*;

   localparam int WORD_BITS = DEF_WORD_BITS;
   localparam int ROUNDS    = DEF_ROUNDS;
   localparam int ROT_RIGHT = DEF_ROT_RIGHT;
   localparam int ROT_LEFT  = DEF_ROT_LEFT;

   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

   localparam int  MAX_IDLE   = 17;
   localparam int  HOLD_OFF   = 400;
   localparam real TIMEOUT_NS = 8_000_000.0;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [FIELD_BITS-1:0] field_type;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   spk_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   spk_rsp_type rsp_data;

   // Predictor state: a copy of the key store and the blocks still owed.
   word_type    round_keys [KEY_DEPTH];
   spk_rsp_type expected_blocks [$];
   spk_rsp_type want_block;

   bit sender_idles      = 1'b1;
   bit sink_idles        = 1'b1;
   int sink_hold_cycles  = 0;

   int error_count    = 0;
   int loads_sent     = 0;
   int encrypts_sent  = 0;
   int decrypts_sent  = 0;
   int ignored_sent   = 0;
   int blocks_checked = 0;

   speck_block_cipher_core #(
      .WORD_BITS (WORD_BITS),
      .ROUNDS    (ROUNDS),
      .ROT_RIGHT (ROT_RIGHT),
      .ROT_LEFT  (ROT_LEFT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_top: FAIL");
      $finish;
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic spk_rsp_type speck_transform(input spk_req_type item);
      word_type    x;
      word_type    y;
      word_type    k;
      word_type    t;
      spk_rsp_type blk;
      x = item.block_high[WORD_BITS-1:0];
      y = item.block_low[WORD_BITS-1:0];
      if (item.command == CMD_ENCRYPT) begin
         for (int r = 0; r < ROUNDS; r++) begin
            k = round_keys[r % KEY_DEPTH];
            x = ({x[ROT_RIGHT-1:0], x[WORD_BITS-1:ROT_RIGHT]} + y) ^ k;
            y = {y[WORD_BITS-ROT_LEFT-1:0], y[WORD_BITS-1:WORD_BITS-ROT_LEFT]} ^ x;
         end
      end else begin
         for (int r = ROUNDS - 1; r >= 0; r--) begin
            k = round_keys[r % KEY_DEPTH];
            t = x ^ y;
            y = {t[ROT_LEFT-1:0], t[WORD_BITS-1:ROT_LEFT]};
            t = (x ^ k) - y;
            x = {t[WORD_BITS-ROT_RIGHT-1:0], t[WORD_BITS-1:WORD_BITS-ROT_RIGHT]};
         end
      end
      blk = '0;
      blk.result_high = x;
      blk.result_low  = y;
      return blk;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic field_type random_word();
      int pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic spk_req_type make_request(input logic [CMD_BITS-1:0] cmd,
                                                input field_type hi, input field_type lo);
      spk_req_type item;
      item.command    = cmd;
      item.key_slot   = KEY_ADDR_BITS'($urandom_range(0, KEY_DEPTH - 1));
      item.key_value  = random_word();
      item.block_high = hi;
      item.block_low  = lo;
      return item;
   endfunction

   function automatic spk_req_type make_key_load(input int slot, input field_type value);
      spk_req_type item;
      item           = make_request(CMD_LOAD, random_word(), random_word());
      item.key_slot  = KEY_ADDR_BITS'(slot);
      item.key_value = value;
      return item;
   endfunction

   function automatic spk_req_type random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         return make_key_load($urandom_range(0, KEY_DEPTH - 1), random_word());
      if (pick < 55) return make_request(CMD_ENCRYPT, random_word(), random_word());
      if (pick < 95) return make_request(CMD_DECRYPT, random_word(), random_word());
      return make_request(CMD_UNUSED, random_word(), random_word());
   endfunction

   // Offers one beat, waits for it to be taken and updates the predictor.
   // Valid is left high so that a following beat can go out back to back.
   task automatic send_request(input spk_req_type item);
      int gap;
      gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      case (item.command)
         CMD_LOAD: begin
            round_keys[item.key_slot] = item.key_value[WORD_BITS-1:0];
            loads_sent++;
         end
         CMD_ENCRYPT: begin
            expected_blocks.push_back(speck_transform(item));
            encrypts_sent++;
         end
         CMD_DECRYPT: begin
            expected_blocks.push_back(speck_transform(item));
            decrypts_sent++;
         end
         default: ignored_sent++;
      endcase
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_blocks.size() != 0);
   endtask

   // ------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------
   initial begin : response_sink
      int stall;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (sink_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (sink_hold_cycles) @(posedge clock);
            sink_hold_cycles = 0;
         end
         stall = sink_idles ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            do @(posedge clock); while (rsp_valid !== 1'b1);
            repeat (stall - 1) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_ready));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_blocks.size() == 0) begin
            $display("%0t: response beat with nothing expected, actual %h", $time, rsp_data);
            error_count++;
         end else begin
            want_block = expected_blocks.pop_front();
            blocks_checked++;
            if (rsp_data.result_high !== want_block.result_high) begin
               $display("%0t: result_high mismatch, expected %h actual %h",
                        $time, want_block.result_high, rsp_data.result_high);
               error_count++;
            end
            if (rsp_data.result_low !== want_block.result_low) begin
               $display("%0t: result_low mismatch, expected %h actual %h",
                        $time, want_block.result_low, rsp_data.result_low);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every key entry is written before the first cipher beat, since each
   // round reads its own entry and an unwritten entry is undefined.
   task automatic test_key_schedule();
      for (int s = 0; s < KEY_DEPTH; s++) begin
         if (s == 0) send_request(make_key_load(s, '1));
         else if (s == 1) send_request(make_key_load(s, '0));
         else send_request(make_key_load(s, {$urandom, $urandom}));
      end
      drain_results();
   endtask

   task automatic test_directed_blocks();
      spk_req_type item;
      spk_rsp_type cipher;
      send_request(make_request(CMD_ENCRYPT, '0, '0));
      send_request(make_request(CMD_ENCRYPT, '1, '1));
      send_request(make_request(CMD_DECRYPT, '0, '0));
      send_request(make_request(CMD_DECRYPT, '1, '1));
      send_request(make_request(CMD_ENCRYPT, '1, '0));
      send_request(make_request(CMD_DECRYPT, '0, '1));
      send_request(make_request(CMD_ENCRYPT, {32{2'b10}}, {32{2'b01}}));
      // The unused command code must leave the key store and the output alone.
      item = make_request(CMD_UNUSED, '1, '1);
      item.key_value = '1;
      send_request(item);
      send_request(make_request(CMD_UNUSED, random_word(), random_word()));
      // Key loads with the extreme slots and values, block fields don't matter.
      send_request(make_key_load(KEY_DEPTH - 1, '1));
      send_request(make_key_load(0, '0));
      send_request(make_request(CMD_ENCRYPT, random_word(), random_word()));
      send_request(make_request(CMD_DECRYPT, random_word(), random_word()));
      // A decrypt of a fresh ciphertext must give the plaintext back.
      item   = make_request(CMD_ENCRYPT, {$urandom, $urandom}, {$urandom, $urandom});
      cipher = speck_transform(item);
      send_request(item);
      send_request(make_request(CMD_DECRYPT, cipher.result_high, cipher.result_low));
      drain_results();
   endtask

   task automatic test_back_to_back();
      sender_idles = 1'b0;
      sink_idles   = 1'b0;
      for (int n = 0; n < 150; n++) send_request(random_request());
      drain_results();
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
   endtask

   // The sink stops taking responses while cipher beats keep coming, so the
   // output register and the round unit both fill and req_ready stays low.
   task automatic test_output_backpressure();
      sender_idles     = 1'b0;
      sink_hold_cycles = HOLD_OFF;
      for (int n = 0; n < 8; n++) begin
         send_request(make_request(n % 2 ? CMD_DECRYPT : CMD_ENCRYPT,
                                   random_word(), random_word()));
      end
      drain_results();
      sender_idles = 1'b1;
   endtask

   task automatic test_random_traffic(input int beats);
      spk_req_type item;
      int          counted;
      int          phase;
      counted = 0;
      while (counted < beats) begin
         // Switch the idling pattern every 250 beats, unused commands not
         // counted: both sides, sink only, sender only.
         phase        = (counted / 250) % 3;
         sender_idles = (phase != 1);
         sink_idles   = (phase != 2);
         item = random_request();
         send_request(item);
         if (item.command != CMD_UNUSED) counted++;
      end
      drain_results();
      sender_idles = 1'b1;
      sink_idles   = 1'b1;
   endtask

   initial begin
      foreach (round_keys[s]) round_keys[s] = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_key_schedule();
      test_directed_blocks();
      test_back_to_back();
      test_output_backpressure();
      test_random_traffic(1550);

      repeat (ROUNDS + 8) @(posedge clock);
      if (expected_blocks.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, expected_blocks.size());
         error_count++;
      end
      $display("Sent %0d key loads, %0d encrypts, %0d decrypts and %0d unused commands.",
               loads_sent, encrypts_sent, decrypts_sent, ignored_sent);
      $display("Checked %0d response beats, %0d errors.", blocks_checked, error_count);
      if (error_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
sv/spk_pkg.sv
sv/spk_ram.sv
sv/spk_round.sv
sv/speck_block_cipher_core.sv
tb/sv/tb_top.sv
